### rtl/tsgq_pkg.sv
// Package for the text stream to glyph quads block.
// Holds screen and limit constants, the glyph descriptor type and the corner table.
// Used by tsgq_state, tsgq_emit and the top level.
package tsgq_pkg;

    // Screen geometry and limits
    localparam int COLUMNS      = 80;
    localparam int LINES        = 64;
    localparam int CHAR_LIMIT   = 4096;
    localparam int VERTEX_LIMIT = 24576;

    // Reset color, packed a b g r
    localparam logic [31:0] COLOR_RESET = 32'hFF00_FFFF;

    // Byte codes
    localparam logic [7:0] GLYPH_MASK   = 8'h7F;
    localparam logic [7:0] CH_PRINTABLE = 8'h20;
    localparam logic [7:0] CH_LEFT      = 8'h08;
    localparam logic [7:0] CH_RIGHT     = 8'h09;
    localparam logic [7:0] CH_DOWN      = 8'h0A;
    localparam logic [7:0] CH_UP        = 8'h0B;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_HOME      = 8'h10;
    localparam logic [7:0] CH_ESC       = 8'h1B;

    // Escape kinds
    localparam logic [7:0] ESC_POS   = 8'h01;
    localparam logic [7:0] ESC_COLOR = 8'h02;

    // Escape phases: none, awaiting code, data bytes from PH_DATA on
    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_CODE = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;

    // Index of the last vertex of a quad
    localparam logic [2:0] LAST_VERTEX = 3'd5;

    // One pending result group: a glyph quad or an escape error
    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  g;
        logic [31:0] color;
        logic        err;
    } t_quad;

    // Per-vertex offsets inside a quad
    typedef struct packed {
        logic dx;
        logic dy;
        logic last;
    } t_corner;

    // Two triangles: (0,0) (1,0) (1,1) / (0,0) (1,1) (0,1)
    function automatic t_corner corner(input logic [2:0] idx);
        t_corner c;
        c = '0;
        unique case (idx)
            3'd0: c = '{dx: 1'b0, dy: 1'b0, last: 1'b0};
            3'd1: c = '{dx: 1'b1, dy: 1'b0, last: 1'b0};
            3'd2: c = '{dx: 1'b1, dy: 1'b1, last: 1'b0};
            3'd3: c = '{dx: 1'b0, dy: 1'b0, last: 1'b0};
            3'd4: c = '{dx: 1'b1, dy: 1'b1, last: 1'b0};
            3'd5: c = '{dx: 1'b0, dy: 1'b1, last: 1'b1};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/tsgq_state.sv
// Cursor, color, escape decoder and counters of the glyph quad block.
// Updates on each input transfer and issues at most one quad or error descriptor.
// Depends on tsgq_pkg.
module tsgq_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_start_of_text,
    output logic                 o_emit,
    output tsgq_pkg::t_quad      o_quad
);
    import tsgq_pkg::*;

    localparam logic [7:0]  COL_MAX = 8'(COLUMNS - 1);
    localparam logic [7:0]  ROW_MAX = 8'(LINES - 1);
    localparam logic [14:0] VC_MAX  = 15'(VERTEX_LIMIT - 6);
    localparam logic [13:0] CC_MAX  = 14'(CHAR_LIMIT);

    logic [7:0]  r_col,   n_col;
    logic [7:0]  r_row,   n_row;
    logic [31:0] r_color, n_color;
    logic [14:0] r_vc,    n_vc;
    logic [12:0] r_cc,    n_cc;
    logic [2:0]  r_ph,    n_ph;
    logic [1:0]  r_kind,  n_kind;
    logic [23:0] r_bytes, n_bytes;
    logic        r_halt,  n_halt;

    // State as seen after an optional start of text
    logic [7:0]  e_col, e_row;
    logic [31:0] e_color;
    logic [14:0] e_vc;
    logic [12:0] e_cc;
    logic [2:0]  e_ph;
    logic [1:0]  e_kind;
    logic [23:0] e_bytes;
    logic        e_halt;

    logic [13:0] cc_inc;
    logic [2:0]  esc_k;
    logic        esc_done;

    assign e_col   = i_start_of_text ? 8'd0        : r_col;
    assign e_row   = i_start_of_text ? 8'd0        : r_row;
    assign e_color = i_start_of_text ? COLOR_RESET : r_color;
    assign e_vc    = i_start_of_text ? 15'd0       : r_vc;
    assign e_cc    = i_start_of_text ? 13'd0       : r_cc;
    assign e_ph    = i_start_of_text ? PH_NONE     : r_ph;
    assign e_kind  = i_start_of_text ? 2'd0        : r_kind;
    assign e_bytes = i_start_of_text ? 24'd0       : r_bytes;
    assign e_halt  = i_start_of_text ? 1'b0        : r_halt;

    assign cc_inc   = {1'b0, e_cc} + 14'd1;
    assign esc_k    = e_ph - PH_DATA;
    // position needs two data bytes, color four
    assign esc_done = (e_kind == ESC_POS[1:0]) ? (esc_k >= 3'd1) : (esc_k >= 3'd3);

    // Byte handling
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_color = r_color;
        n_vc    = r_vc;
        n_cc    = r_cc;
        n_ph    = r_ph;
        n_kind  = r_kind;
        n_bytes = r_bytes;
        n_halt  = r_halt;
        o_emit  = 1'b0;
        o_quad.x     = e_col;
        o_quad.y     = e_row;
        o_quad.g     = i_text_byte & GLYPH_MASK;
        o_quad.color = e_color;
        o_quad.err   = 1'b0;

        if (i_accept) begin
            n_col   = e_col;
            n_row   = e_row;
            n_color = e_color;
            n_vc    = e_vc;
            n_cc    = e_cc;
            n_ph    = e_ph;
            n_kind  = e_kind;
            n_bytes = e_bytes;
            n_halt  = e_halt;

            if (!e_halt) begin
                n_cc = cc_inc[12:0];
                if (cc_inc >= CC_MAX) begin
                    n_halt = 1'b1;
                end

                priority if (e_ph == PH_CODE) begin
                    // escape code byte
                    if (i_text_byte == ESC_POS || i_text_byte == ESC_COLOR) begin
                        n_kind  = i_text_byte[1:0];
                        n_bytes = 24'd0;
                        n_ph    = PH_DATA;
                    end else begin
                        o_emit     = 1'b1;
                        o_quad.err = 1'b1;
                        n_ph       = PH_NONE;
                        n_kind     = 2'd0;
                    end
                end else if (e_ph >= PH_DATA) begin
                    // escape data byte
                    if (esc_done) begin
                        if (e_kind == ESC_POS[1:0]) begin
                            n_col = e_bytes[7:0];
                            n_row = i_text_byte;
                        end else begin
                            n_color = {i_text_byte, e_bytes};
                        end
                        n_ph    = PH_NONE;
                        n_kind  = 2'd0;
                        n_bytes = 24'd0;
                    end else begin
                        n_bytes = e_bytes | (24'(i_text_byte) << {esc_k[1:0], 3'b000});
                        n_ph    = e_ph + 3'd1;
                    end
                end else if (i_text_byte < CH_PRINTABLE) begin
                    // control codes
                    unique case (i_text_byte)
                        CH_LEFT:  n_col = (e_col > 8'd0) ? e_col - 8'd1 : 8'd0;
                        CH_RIGHT: n_col = (e_col < COL_MAX) ? e_col + 8'd1 : COL_MAX;
                        CH_DOWN:  n_row = (e_row < ROW_MAX) ? e_row + 8'd1 : ROW_MAX;
                        CH_UP:    n_row = (e_row > 8'd0) ? e_row - 8'd1 : 8'd0;
                        CH_CR:    n_col = 8'd0;
                        CH_HOME: begin
                            n_col = 8'd0;
                            n_row = 8'd0;
                        end
                        CH_ESC:   n_ph = PH_CODE;
                        default:  ;
                    endcase
                end else begin
                    // printable glyph
                    if (e_vc < VC_MAX && e_col <= COL_MAX) begin
                        o_emit = 1'b1;
                        n_vc   = e_vc + 15'd6;
                        n_col  = e_col + 8'd1;
                    end else begin
                        n_halt = 1'b1;
                    end
                end

                // halting drops an unfinished escape
                if (n_halt) begin
                    n_ph    = PH_NONE;
                    n_kind  = 2'd0;
                    n_bytes = 24'd0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= 8'd0;
            r_row   <= 8'd0;
            r_color <= COLOR_RESET;
            r_vc    <= 15'd0;
            r_cc    <= 13'd0;
            r_ph    <= PH_NONE;
            r_kind  <= 2'd0;
            r_bytes <= 24'd0;
            r_halt  <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_color <= n_color;
            r_vc    <= n_vc;
            r_cc    <= n_cc;
            r_ph    <= n_ph;
            r_kind  <= n_kind;
            r_bytes <= n_bytes;
            r_halt  <= n_halt;
        end
    end

endmodule

### rtl/tsgq_emit.sv
// Result register and vertex sequencer of the glyph quad block.
// Holds one descriptor and sends its six vertices, or one error result.
// Depends on tsgq_pkg.
module tsgq_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tsgq_pkg::t_quad      i_quad,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_pos_x,
    output logic [7:0]           o_pos_y,
    output logic [7:0]           o_tex_u,
    output logic                 o_tex_v,
    output logic [31:0]          o_rgba,
    output logic                 o_last_of_quad,
    output logic                 o_escape_error
);
    import tsgq_pkg::*;

    logic        r_busy;
    logic [2:0]  r_idx;
    t_quad       r_quad;
    t_corner     cur;
    logic        xfer;
    logic        done;

    assign cur     = corner(r_idx);
    assign o_valid = r_busy;
    assign xfer    = r_busy && i_ready;
    assign done    = xfer && (r_quad.err || r_idx == LAST_VERTEX);
    // slot opens in the cycle the final transfer goes out
    assign o_free  = !r_busy || done;

    // Vertex fields; an error result carries zeros
    always_comb begin
        if (r_quad.err) begin
            o_pos_x        = 8'd0;
            o_pos_y        = 8'd0;
            o_tex_u        = 8'd0;
            o_tex_v        = 1'b0;
            o_rgba         = 32'd0;
            o_last_of_quad = 1'b1;
            o_escape_error = 1'b1;
        end else begin
            o_pos_x        = r_quad.x + 8'(cur.dx);
            o_pos_y        = r_quad.y + 8'(cur.dy);
            o_tex_u        = r_quad.g + 8'(cur.dx);
            o_tex_v        = cur.dy;
            o_rgba         = r_quad.color;
            o_last_of_quad = cur.last;
            o_escape_error = 1'b0;
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (xfer) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Descriptor payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quad <= i_quad;
        end
    end

endmodule

### rtl/text_stream_to_glyph_quads_core.sv
// Text stream to glyph quads: top level.
// The first result is registered and appears in the cycle after the input transfer.
// A printable byte's six vertices, or an escape error result, leave the result register;
// input waits until the last one is taken. Other bytes are taken one per cycle while no result is pending.
// Reset: synchronous, active low; clears cursor, color, counters, escape, halt and the pending result.
module text_stream_to_glyph_quads_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_start_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pos_x,
    output logic [7:0]  o_pos_y,
    output logic [7:0]  o_tex_u,
    output logic        o_tex_v,
    output logic [31:0] o_rgba,
    output logic        o_last_of_quad,
    output logic        o_escape_error
);
    import tsgq_pkg::*;

    logic   accept;
    logic   emit;
    logic   free;
    t_quad  quad;

    assign o_ready = free;
    assign accept  = i_valid && free;

    // Byte decoder and screen state
    tsgq_state u_state (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_text_byte     (i_text_byte),
        .i_start_of_text (i_start_of_text),
        .o_emit          (emit),
        .o_quad          (quad)
    );

    // Vertex sequencer
    tsgq_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (emit),
        .i_quad         (quad),
        .o_free         (free),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_rgba         (o_rgba),
        .o_last_of_quad (o_last_of_quad),
        .o_escape_error (o_escape_error)
    );

    // An error result always closes its group
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_escape_error |-> o_last_of_quad)
        else $error("escape error without last_of_quad");

    // With nothing pending the input side is open
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while no result pending");

    // A descriptor issue shows up as a result next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_valid)
        else $error("issued descriptor did not reach the output");

    // Input is only taken when the result slot is open
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!o_valid || (i_ready && o_last_of_quad)))
        else $error("descriptor loaded over a pending result");

endmodule

### bench/tsgq_vertex_checker.sv
// Scoreboard for the text stream to glyph quads core: watches both channels,
// predicts the vertex results of every byte transfer and compares them in order.
// Depends on tsgq_pkg for the screen limits, byte codes and escape phases.
`timescale 1ns / 100ps

module tsgq_vertex_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_start_of_text,
    input  logic        i_vtx_valid,
    input  logic        i_vtx_ready,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [7:0]  i_tex_u,
    input  logic        i_tex_v,
    input  logic [31:0] i_rgba,
    input  logic        i_last_of_quad,
    input  logic        i_escape_error,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_bytes_seen,
    output int          o_vertices_checked,
    output int          o_errors_seen
);
    import tsgq_pkg::*;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  u;
        logic        v;
        logic [31:0] rgba;
        logic        last;
        logic        err;
    } t_vertex;

    // Corner offsets of the two triangles, bit i = vertex i
    localparam logic [5:0] QUAD_DX = 6'b010110;
    localparam logic [5:0] QUAD_DY = 6'b110100;

    t_vertex vertices_due[$];

    // Screen state as seen by the predictor
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [31:0] cur_color;
    logic [14:0] vtx_cnt;
    logic [12:0] char_cnt;
    logic [2:0]  esc_phase;
    logic [7:0]  esc_code;
    logic [23:0] esc_data;
    logic        halted;

    int fail_cnt     = 0;
    int bytes_cnt    = 0;
    int checked_cnt  = 0;
    int err_cnt      = 0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic drop_escape();
        esc_phase = PH_NONE;
        esc_code  = '0;
        esc_data  = '0;
    endtask

    task automatic clear_screen();
        cur_col   = '0;
        cur_row   = '0;
        cur_color = COLOR_RESET;
        vtx_cnt   = '0;
        char_cnt  = '0;
        halted    = 1'b0;
        drop_escape();
    endtask

    // Predict the results of one byte transfer and queue them
    task automatic render_byte(input logic [7:0] c, input logic sot);
        int      next_cnt;
        int      k;
        int      need;
        logic    dx;
        logic    dy;
        logic [7:0] g;
        t_vertex vtx;

        if (sot)
            clear_screen();
        if (halted)
            return;

        // Every handled byte counts; the one reaching the limit is still handled
        next_cnt = int'(char_cnt) + 1;
        if (next_cnt >= CHAR_LIMIT)
            halted = 1'b1;
        char_cnt = 13'(next_cnt);

        if (esc_phase == PH_CODE) begin
            if (c == ESC_POS || c == ESC_COLOR) begin
                esc_code  = c;
                esc_data  = '0;
                esc_phase = PH_DATA;
            end else begin
                // Bad escape code: one error result, byte dropped
                vtx      = '0;
                vtx.last = 1'b1;
                vtx.err  = 1'b1;
                vertices_due.push_back(vtx);
                esc_phase = PH_NONE;
                esc_code  = '0;
            end
        end else if (esc_phase >= PH_DATA) begin
            k    = int'(esc_phase - PH_DATA);
            need = (esc_code == ESC_POS) ? 2 : 4;
            if (k + 1 >= need) begin
                if (esc_code == ESC_POS) begin
                    cur_col = esc_data[7:0];
                    cur_row = c;
                end else begin
                    cur_color = {c, esc_data};
                end
                drop_escape();
            end else begin
                esc_data  = esc_data | (24'(c) << (8 * k));
                esc_phase = esc_phase + 3'd1;
            end
        end else if (c < CH_PRINTABLE) begin
            // Cursor moves clamp at the screen edges
            case (c)
                CH_LEFT:  cur_col = (cur_col > 0) ? cur_col - 8'd1 : 8'd0;
                CH_RIGHT: cur_col = (cur_col < COLUMNS - 1) ? cur_col + 8'd1
                                                             : 8'(COLUMNS - 1);
                CH_DOWN:  cur_row = (cur_row < LINES - 1) ? cur_row + 8'd1
                                                           : 8'(LINES - 1);
                CH_UP:    cur_row = (cur_row > 0) ? cur_row - 8'd1 : 8'd0;
                CH_CR:    cur_col = '0;
                CH_HOME: begin
                    cur_col = '0;
                    cur_row = '0;
                end
                CH_ESC:   esc_phase = PH_CODE;
                default: ;
            endcase
        end else if (vtx_cnt < VERTEX_LIMIT - 6 && cur_col <= COLUMNS - 1) begin
            // Glyph quad: six vertices around the cursor cell
            g = c & GLYPH_MASK;
            for (int i = 0; i < 6; i++) begin
                dx       = QUAD_DX[i];
                dy       = QUAD_DY[i];
                vtx.x    = cur_col + 8'(dx);
                vtx.y    = cur_row + 8'(dy);
                vtx.u    = g + 8'(dx);
                vtx.v    = dy;
                vtx.rgba = cur_color;
                vtx.last = (i == 5);
                vtx.err  = 1'b0;
                vertices_due.push_back(vtx);
            end
            vtx_cnt = vtx_cnt + 15'd6;
            cur_col = cur_col + 8'd1;
        end else begin
            halted = 1'b1;
        end

        // Halting cuts off any escape in progress
        if (halted)
            drop_escape();
    endtask

    task automatic check_vertex();
        t_vertex got;
        t_vertex want;
        string   diffs;

        got = '{x: i_pos_x, y: i_pos_y, u: i_tex_u, v: i_tex_v, rgba: i_rgba,
                last: i_last_of_quad, err: i_escape_error};
        if (got.err === 1'b1)
            err_cnt++;
        if (vertices_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result x=%0d y=%0d u=%0d err=%b",
                                    got.x, got.y, got.u, got.err));
            return;
        end
        want  = vertices_due.pop_front();
        diffs = "";
        if (got.x !== want.x)
            diffs = {diffs, $sformatf(" pos_x %0d/%0d", got.x, want.x)};
        if (got.y !== want.y)
            diffs = {diffs, $sformatf(" pos_y %0d/%0d", got.y, want.y)};
        if (got.u !== want.u)
            diffs = {diffs, $sformatf(" tex_u %0d/%0d", got.u, want.u)};
        if (got.v !== want.v)
            diffs = {diffs, $sformatf(" tex_v %b/%b", got.v, want.v)};
        if (got.rgba !== want.rgba)
            diffs = {diffs, $sformatf(" rgba %h/%h", got.rgba, want.rgba)};
        if (got.last !== want.last)
            diffs = {diffs, $sformatf(" last_of_quad %b/%b", got.last, want.last)};
        if (got.err !== want.err)
            diffs = {diffs, $sformatf(" escape_error %b/%b", got.err, want.err)};
        if (diffs != "")
            flag_mismatch($sformatf("result %0d (got/exp):%s", checked_cnt, diffs));
        checked_cnt++;
    endtask

    // Results are checked before the same-edge byte is predicted: results are
    // registered, so a result can never belong to that byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_screen();
            vertices_due.delete();
        end else begin
            if (i_vtx_valid && i_vtx_ready)
                check_vertex();
            if (i_byte_valid && i_byte_ready) begin
                bytes_cnt++;
                render_byte(i_text_byte, i_start_of_text);
            end
        end
        o_fail_count       <= fail_cnt;
        o_pending          <= vertices_due.size();
        o_bytes_seen       <= bytes_cnt;
        o_vertices_checked <= checked_cnt;
        o_errors_seen      <= err_cnt;
    end

endmodule

### bench/text_stream_to_glyph_quads_core_tb.sv
// Testbench top for text_stream_to_glyph_quads_core: clock, reset, byte stimulus,
// receiver stalls and the verdict. Checking is done by tsgq_vertex_checker.
// Depends on tsgq_pkg, tsgq_vertex_checker and the core RTL.
`timescale 1ns / 100ps

module text_stream_to_glyph_quads_core_tb;
    import tsgq_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_WAIT  = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  text_byte = '0;
    logic        start_of_text = 1'b0;
    logic        vtx_valid;
    logic        vtx_ready = 1'b0;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  tex_u;
    logic        tex_v;
    logic [31:0] rgba;
    logic        last_of_quad;
    logic        escape_error;

    int fail_count;
    int pending;
    int bytes_seen;
    int vertices_checked;
    int errors_seen;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cycle_cnt    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_stream_to_glyph_quads_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (byte_valid),
        .o_ready         (byte_ready),
        .i_text_byte     (text_byte),
        .i_start_of_text (start_of_text),
        .o_valid         (vtx_valid),
        .i_ready         (vtx_ready),
        .o_pos_x         (pos_x),
        .o_pos_y         (pos_y),
        .o_tex_u         (tex_u),
        .o_tex_v         (tex_v),
        .o_rgba          (rgba),
        .o_last_of_quad  (last_of_quad),
        .o_escape_error  (escape_error)
    );

    tsgq_vertex_checker i_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_byte_valid       (byte_valid),
        .i_byte_ready       (byte_ready),
        .i_text_byte        (text_byte),
        .i_start_of_text    (start_of_text),
        .i_vtx_valid        (vtx_valid),
        .i_vtx_ready        (vtx_ready),
        .i_pos_x            (pos_x),
        .i_pos_y            (pos_y),
        .i_tex_u            (tex_u),
        .i_tex_v            (tex_v),
        .i_rgba             (rgba),
        .i_last_of_quad     (last_of_quad),
        .i_escape_error     (escape_error),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_bytes_seen       (bytes_seen),
        .o_vertices_checked (vertices_checked),
        .o_errors_seen      (errors_seen)
    );

    // Receiver back-pressure
    always @(posedge clk)
        vtx_ready <= ($urandom_range(99) >= rx_stall_pct);

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
            $display("** text_stream_to_glyph_quads_core: FAILED **");
            $finish;
        end
    end

    // One byte transfer, with a random idle gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic sot);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid    <= 1'b1;
        text_byte     <= b;
        start_of_text <= sot;
        do @(posedge clk); while (!byte_ready);
    endtask

    task automatic send_printable();
        send_byte(8'($urandom_range(255, CH_PRINTABLE)), 1'b0);
    endtask

    // Edges of the fields, every control code and the escape corner cases
    task automatic directed_bytes();
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);         // unused control, no result
        send_byte(8'hFF, 1'b0);         // high bit masked off
        send_byte(CH_PRINTABLE, 1'b0);
        send_byte(CH_HOME, 1'b0);
        send_byte(CH_LEFT, 1'b0);       // clamps at column 0
        send_byte(CH_UP, 1'b0);         // clamps at row 0
        send_byte(CH_ESC, 1'b0);        // place cursor off screen
        send_byte(ESC_POS, 1'b0);
        send_byte(8'd100, 1'b0);
        send_byte(8'd200, 1'b0);
        send_byte(CH_RIGHT, 1'b0);      // pulled back to last column
        send_byte(CH_DOWN, 1'b0);       // pulled back to last line
        send_byte(CH_CR, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(ESC_COLOR, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(CH_ESC, 1'b0);        // bad escape code
        send_byte(8'h07, 1'b0);
        // last column on row 255: vertex rows wrap, then column overflow halts
        send_byte(CH_ESC, 1'b0);
        send_byte(ESC_POS, 1'b0);
        send_byte(8'(COLUMNS - 1), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7E, 1'b0);         // past the last column: halts
        // color escape cut off by start of text
        send_byte(CH_ESC, 1'b1);
        send_byte(ESC_COLOR, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // One random group of bytes; mostly well-formed, some noise and breaks
    task automatic random_burst(output int n);
        int         pick;
        int         len;
        logic [7:0] code;

        pick = $urandom_range(99);
        n    = 0;
        if (pick < 35) begin
            len = $urandom_range(8, 1);
            repeat (len) send_printable();
            n = len;
        end else if (pick < 50) begin
            case ($urandom_range(6))
                0: code = CH_LEFT;
                1: code = CH_RIGHT;
                2: code = CH_DOWN;
                3: code = CH_UP;
                4: code = CH_CR;
                5: code = CH_HOME;
                default: code = 8'($urandom_range(CH_PRINTABLE - 1, 0));
            endcase
            send_byte(code, 1'b0);
            n = 1;
        end else if (pick < 60) begin
            send_byte(CH_ESC, 1'b0);
            send_byte(ESC_POS, 1'b0);
            if ($urandom_range(3) != 0)
                send_byte(8'($urandom_range(COLUMNS - 1, 0)), 1'b0);
            else
                send_byte(8'($urandom_range(255, 0)), 1'b0);
            send_byte(8'($urandom_range(255, 0)), 1'b0);
            n = 4;
        end else if (pick < 70) begin
            send_byte(CH_ESC, 1'b0);
            send_byte(ESC_COLOR, 1'b0);
            repeat (4) send_byte(8'($urandom_range(255, 0)), 1'b0);
            n = 6;
        end else if (pick < 77) begin
            do code = 8'($urandom_range(255, 0));
            while (code == ESC_POS || code == ESC_COLOR);
            send_byte(CH_ESC, 1'b0);
            send_byte(code, 1'b0);
            n = 2;
        end else if (pick < 85) begin
            send_byte(8'($urandom_range(255, 0)), 1'b1);
            n = 1;
        end else if (pick < 92) begin
            // escape broken off by a new start of text
            len = $urandom_range(3, 0);
            send_byte(CH_ESC, 1'b0);
            if (len > 0)
                send_byte(($urandom_range(1) != 0) ? ESC_POS : ESC_COLOR, 1'b0);
            repeat (len > 0 ? len - 1 : 0) send_byte(8'($urandom_range(255, 0)), 1'b0);
            send_byte(8'($urandom_range(255, 0)), 1'b1);
            n = len + 2;
        end else begin
            send_byte(8'($urandom_range(255, 0)), 1'b0);
            n = 1;
        end
    endtask

    initial begin
        int sent;
        int burst;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_bytes();

        // Flow-control mixes: none, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct <= 59; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct <= 0;  rx_stall_pct <= 59; end
                default: begin tx_idle_pct <= 36; rx_stall_pct <= 36; end
            endcase
            send_byte(8'($urandom_range(255, CH_PRINTABLE)), 1'b1);
            sent = 1;
            while (sent < PHASE_ITEMS) begin
                random_burst(burst);
                sent += burst;
            end
        end

        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d byte transfers and %0d checked results (%0d escape errors),",
                 bytes_seen, vertices_checked, errors_seen);
        $display("with directed edge cases and random bursts under four flow-control mixes.");
        if (fail_count == 0) begin
            $display("** text_stream_to_glyph_quads_core: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** text_stream_to_glyph_quads_core: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tsgq_pkg.sv
rtl/tsgq_state.sv
rtl/tsgq_emit.sv
rtl/text_stream_to_glyph_quads_core.sv
bench/tsgq_vertex_checker.sv
bench/text_stream_to_glyph_quads_core_tb.sv
